@@ design/bfha_pkg.sv @@
// Package for the best-fit heap allocator: shared constants, response codes,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package bfha_pkg;

  localparam int HdrBytes       = 4;
  localparam int ArenaWordsDef  = 1024;
  localparam int ArenaRstBytes  = 4096;
  localparam int CfgW           = 13;
  localparam int ReqW           = 13;
  localparam int OffW           = 12;
  localparam int NeedW          = 14;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    logic    load_req;
    logic    init_arena;
    logic    rd_pos;
    logic    rd_next;
    logic    walk_step;
    logic    start_merge;
    logic    merge_step;
    logic    merge_wr;
    logic    free_wr;
    logic    split_wr;
    logic    commit_wr;
    logic    out_load;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic in_free;
    logic req_zero;
    logic free_bad;
    logic is_free;
    logic pos_end;
    logic next_end;
    logic hdr_alloc;
    logic pos_hit;
    logic found;
    logic exact;
  } sts_t;

endpackage
`default_nettype wire

@@ design/bfha_dp.sv @@
// Datapath of the best-fit heap allocator: header memory, walk pointers,
// best-fit tracking and result registers. Depends on bfha_pkg.
`default_nettype none
module bfha_dp import bfha_pkg::*; #(
  parameter int ARENA_WORDS = ArenaWordsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            arena_bytes_we_i,
  input  wire logic [CfgW-1:0] arena_bytes_i,
  input  wire logic            req_type_i,
  input  wire logic [ReqW-1:0] request_bytes_i,
  input  wire logic            has_pointer_i,
  input  wire logic [OffW-1:0] payload_offset_i,
  input  wire cmd_t            cmd_i,
  output sts_t                 sts_o,
  output logic [OffW-1:0]      result_offset_o,
  output logic [1:0]           status_o
);

  localparam int AW     = (ARENA_WORDS > 1) ? $clog2(ARENA_WORDS) : 1;
  localparam int BYTE_W = AW + 3;
  localparam int SW     = BYTE_W - 2;
  localparam int HDR_W  = SW + 1;
  localparam int CW     = (BYTE_W > NeedW) ? BYTE_W : NeedW;
  localparam int LimMax = ARENA_WORDS * 4;
  localparam int RstLim = (LimMax < ArenaRstBytes) ? LimMax : ArenaRstBytes;

  logic [HDR_W-1:0]  mem_q [ARENA_WORDS];
  logic [HDR_W-1:0]  rd_q;
  logic [BYTE_W-1:0] limit_q, limit_d;
  logic [BYTE_W-1:0] pos_q, next_q, total_q, best_q, best_size_q;
  logic              found_q, is_free_q;
  logic [NeedW-1:0]  need_q;
  logic [OffW-1:0]   target_q, res_off_q;
  logic [OffW-1:0]   result_offset_q;
  logic [1:0]        status_q;

  logic [NeedW-1:0]  rnd;
  logic [BYTE_W-1:0] rd_size, need_b, hdr4;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [HDR_W-1:0]  wr_data;
  logic              wr_en, fits;

  assign hdr4    = BYTE_W'(HdrBytes);
  assign rd_size = {rd_q[HDR_W-1:1], 2'b00};
  assign need_b  = BYTE_W'(need_q);

  // round the arena size up to a word, raise it to at least 8 bytes, clamp to the memory
  always_comb begin
    rnd = (NeedW'(arena_bytes_i) + NeedW'(3)) & ~NeedW'(3);
    if (rnd < NeedW'(8)) begin
      limit_d = BYTE_W'(8);
    end else if (CW'(rnd) > CW'(LimMax)) begin
      limit_d = BYTE_W'(LimMax);
    end else begin
      limit_d = BYTE_W'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= BYTE_W'(RstLim);
    end else if (arena_bytes_we_i) begin
      limit_q <= limit_d;
    end
  end

  assign rd_addr = cmd_i.rd_next ? next_q[AW+1:2] : pos_q[AW+1:2];

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos_q[AW+1:2];
    wr_data = '0;
    if (cmd_i.init_arena) begin
      wr_addr = '0;
      wr_data = {SW'((limit_q - hdr4) >> 2), 1'b0};
    end else if (cmd_i.merge_wr) begin
      wr_data = {SW'(total_q >> 2), 1'b0};
    end else if (cmd_i.free_wr) begin
      wr_data = {SW'(rd_size >> 2), 1'b0};
    end else if (cmd_i.split_wr) begin
      wr_addr = AW'((best_q + hdr4 + need_b) >> 2);
      wr_data = {SW'((best_size_q - need_b - hdr4) >> 2), 1'b0};
    end else if (cmd_i.commit_wr) begin
      wr_addr = best_q[AW+1:2];
      wr_data = {SW'(need_b >> 2), 1'b1};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign fits = (CW'(total_q) >= CW'(need_q)) && (!found_q || (total_q < best_size_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      is_free_q <= 1'b0;
      status_q  <= '0;
    end else begin
      if (cmd_i.load_req) begin
        found_q   <= 1'b0;
        is_free_q <= req_type_i;
      end else if (cmd_i.merge_wr && fits) begin
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        status_q <= cmd_i.code;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      pos_q     <= '0;
      res_off_q <= '0;
      need_q    <= (NeedW'(request_bytes_i) + NeedW'(3)) & ~NeedW'(3);
      target_q  <= payload_offset_i - OffW'(HdrBytes);
    end
    if (cmd_i.walk_step) begin
      pos_q <= pos_q + hdr4 + rd_size;
    end
    if (cmd_i.start_merge) begin
      total_q <= rd_size;
      next_q  <= pos_q + hdr4 + rd_size;
    end
    if (cmd_i.merge_step) begin
      total_q <= total_q + hdr4 + rd_size;
      next_q  <= next_q + hdr4 + rd_size;
    end
    if (cmd_i.merge_wr) begin
      pos_q <= next_q;
      if (fits) begin
        best_q      <= pos_q;
        best_size_q <= total_q;
      end
    end
    if (cmd_i.commit_wr) begin
      res_off_q <= OffW'(best_q + hdr4);
    end
    if (cmd_i.out_load) begin
      result_offset_q <= res_off_q;
    end
  end

  always_comb begin
    sts_o.in_free   = req_type_i;
    sts_o.req_zero  = (request_bytes_i == '0);
    sts_o.free_bad  = !has_pointer_i || (payload_offset_i < OffW'(HdrBytes));
    sts_o.is_free   = is_free_q;
    sts_o.pos_end   = (pos_q >= limit_q);
    sts_o.next_end  = (next_q >= limit_q);
    sts_o.hdr_alloc = rd_q[0];
    sts_o.pos_hit   = (CW'(pos_q) == CW'(target_q));
    sts_o.found     = found_q;
    sts_o.exact     = (best_size_q == need_b);
  end

  assign result_offset_o = result_offset_q;
  assign status_o        = status_q;

`ifndef NO_ASSERTIONS
  a_commit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.split_wr || cmd_i.commit_wr) |-> found_q)
    else $error("block placed without a fitting candidate");
  a_limit_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q >= BYTE_W'(8))
    else $error("arena limit below two words");
  a_merge_in_arena: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge_wr |-> (next_q <= limit_q))
    else $error("merged block runs past the arena end");
`endif

endmodule
`default_nettype wire

@@ design/bfha_ctrl.sv @@
// Controller of the best-fit heap allocator: sequences the header walk,
// merges, splits and the response. Depends on bfha_pkg.
`default_nettype none
module bfha_ctrl import bfha_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic arena_bytes_we_i,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_EVAL   = 10'b0000001000,
    S_MRD    = 10'b0000010000,
    S_MEVAL  = 10'b0000100000,
    S_MWR    = 10'b0001000000,
    S_SPLIT  = 10'b0010000000,
    S_COMMIT = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_arena = 1'b1;
        // a size write in this cycle needs the header rewritten once more
        if (arena_bytes_we_i) begin
          state_d = S_INIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (arena_bytes_we_i) begin
          state_d = S_INIT;
        end else if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (sts_i.in_free && sts_i.free_bad) begin
            code_d  = ST_IGNORED;
            state_d = S_RESP;
          end else if (!sts_i.in_free && sts_i.req_zero) begin
            code_d  = ST_NOFIT;
            state_d = S_RESP;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (!sts_i.pos_end) begin
          cmd_o.rd_pos = 1'b1;
          state_d = S_EVAL;
        end else if (sts_i.is_free) begin
          code_d  = ST_IGNORED;
          state_d = S_RESP;
        end else if (!sts_i.found) begin
          code_d  = ST_NOFIT;
          state_d = S_RESP;
        end else if (sts_i.exact) begin
          state_d = S_COMMIT;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_EVAL: begin
        if (sts_i.is_free && sts_i.pos_hit) begin
          cmd_o.free_wr = 1'b1;
          code_d  = ST_DONE;
          state_d = S_RESP;
        end else if (sts_i.is_free || sts_i.hdr_alloc) begin
          cmd_o.walk_step = 1'b1;
          state_d = S_RD;
        end else begin
          cmd_o.start_merge = 1'b1;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        if (sts_i.next_end) begin
          state_d = S_MWR;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (!sts_i.hdr_alloc) begin
          cmd_o.merge_step = 1'b1;
          state_d = S_MRD;
        end else begin
          state_d = S_MWR;
        end
      end
      S_MWR: begin
        cmd_o.merge_wr = 1'b1;
        state_d = S_RD;
      end
      S_SPLIT: begin
        cmd_o.split_wr = 1'b1;
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit_wr = 1'b1;
        code_d  = ST_DONE;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
    cmd_o.code = code_q;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      code_q      <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a size write takes the idle cycle, so hold the input off during it
  assign in_stall_o  = (state_q != S_IDLE) || arena_bytes_we_i;
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !arena_bytes_we_i) |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");
  a_split_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPLIT) |=> (state_q == S_COMMIT))
    else $error("split not followed by commit");
`endif

endmodule
`default_nettype wire

@@ design/best_fit_heap_allocator.sv @@
// Top level of the best-fit heap allocator: joins controller and datapath.
// Depends on bfha_pkg, bfha_ctrl, bfha_dp.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o) takes one request word: an
//   allocate (req_type 0, request_bytes) or a free (req_type 1, has_pointer,
//   payload_offset). One request is worked at a time; in_stall_o is high
//   from acceptance until its result is handed to the output register.
// - Output channel (out_valid_o / out_stall_i) carries result_offset and
//   status from a register; while the receiver stalls, the word holds and
//   the block still accepts and works the next request.
// - Latency is set by the header walk over the header memory (one read
//   per cycle, registered): each block header visited is read and then
//   evaluated, each block merged likewise, each merge is written back, and
//   setup, split and commit follow. A free stops at its block. Zero-size
//   allocates and null or low pointers answer without a walk.
// - arena_bytes_we_i rewrites the arena size and rebuilds the arena as one
//   free block, dropping every allocation; write it only idle.
// - Reset loads a 4096-byte arena (clamped to the memory) and writes its
//   first header before taking requests.
`default_nettype none
module best_fit_heap_allocator import bfha_pkg::*; #(
  parameter int ARENA_WORDS = ArenaWordsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            arena_bytes_we_i,
  input  wire logic [CfgW-1:0] arena_bytes_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            req_type_i,
  input  wire logic [ReqW-1:0] request_bytes_i,
  input  wire logic            has_pointer_i,
  input  wire logic [OffW-1:0] payload_offset_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [OffW-1:0]      result_offset_o,
  output logic [1:0]           status_o
);

  cmd_t cmd;
  sts_t sts;

  // sequence the walk
  bfha_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .arena_bytes_we_i (arena_bytes_we_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  // hold headers, pointers and the result word
  bfha_dp #(
    .ARENA_WORDS (ARENA_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .arena_bytes_we_i (arena_bytes_we_i),
    .arena_bytes_i    (arena_bytes_i),
    .req_type_i       (req_type_i),
    .request_bytes_i  (request_bytes_i),
    .has_pointer_i    (has_pointer_i),
    .payload_offset_i (payload_offset_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_offset_o  (result_offset_o),
    .status_o         (status_o)
  );

endmodule
`default_nettype wire
